// ===== src/mpe_pkg.sv =====
// ----------------------------------------------------------------------------
// mpe_pkg: shared types and constants of the multiset partition enumerator
// Sequencer states, configuration register indexes and field widths.
// ----------------------------------------------------------------------------
package mpe_pkg;

    localparam int COMP_BITS     = 2;
    localparam int COUNT_BITS    = 4;
    localparam int NUM_MULT_REGS = 4;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 5;

    localparam logic [CFG_IDX_BITS-1:0] CFG_COMPONENT_COUNT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_PARTS       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MULT_0          = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MULT_1          = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MULT_2          = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MULT_3          = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RS_PUSH,
        ST_M5_CHK,
        ST_M5_EV,
        ST_M2_START,
        ST_M2_RD,
        ST_M2_EV,
        ST_M2_END,
        ST_EM_HI,
        ST_EM_RD,
        ST_EM_ACC,
        ST_EM_OUT,
        ST_EX_OUT
    } mpe_state_t;

endpackage

// ===== src/multiset_partition_enumerator_core.sv =====
// ----------------------------------------------------------------------------
// multiset_partition_enumerator_core
// Steps through the partitions of a multiset (Algorithm M) one per transaction.
// ----------------------------------------------------------------------------
// A restart transaction latches the multiplicities, component count and part
// limit, and emits the first partition (one part). Each advance transaction
// forms the next partition and emits one result per part, with last_part on
// the final one; when no partition is left a single exhausted result comes
// out. All stack entries sit in one synchronous memory (one read, one write
// per cycle, read data registered), so the time an item costs grows with the
// stack entries the sequencer visits in the backtrack and copy passes and with
// the entries and parts it reads during emission. A restart writes one entry
// per component, and an advance that backs up and rebuilds many levels visits
// the most entries; a stalled result register holds the sequencer until free.
// Configuration writes are taken at any time, but must only be issued while
// the block is idle; they act at the next restart.
module multiset_partition_enumerator_core #(
    parameter int MAX_COMPONENTS = 4,
    parameter int MAX_PARTS      = 16,
    parameter int MULT_BITS      = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mpe_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [mpe_pkg::CFG_DATA_BITS-1:0] cfg_data,
    // input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             restart,
    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [3:0]                       part_index,
    output logic [3:0]                       count_0,
    output logic [3:0]                       count_1,
    output logic [3:0]                       count_2,
    output logic [3:0]                       count_3,
    output logic                             last_part,
    output logic                             exhausted
);
    import mpe_pkg::*;

    localparam int STACK_DEPTH = MAX_COMPONENTS * (MAX_PARTS + 1);
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SW  = $clog2(STACK_DEPTH + 1);
    localparam int KW  = $clog2(2 * STACK_DEPTH + 1);
    localparam int LW  = $clog2(MAX_PARTS + 1);
    localparam int PW  = MULT_BITS + LW;
    localparam int MAX_M = (MAX_COMPONENTS < NUM_MULT_REGS) ? MAX_COMPONENTS
                                                            : NUM_MULT_REGS;

    typedef struct packed {
        logic [COMP_BITS-1:0] comp;
        logic [MULT_BITS-1:0] tot;
        logic [MULT_BITS-1:0] rem;
    } entry_t;

    // ---------------- configuration registers ----------------
    logic [2:0] component_count_reg;
    logic [4:0] max_parts_reg;
    logic [3:0] mult_reg [NUM_MULT_REGS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            component_count_reg <= 3'd1;
            max_parts_reg       <= 5'd0;
            for (int i = 0; i < NUM_MULT_REGS; i++)
            begin
                mult_reg[i] <= 4'd1;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_COMPONENT_COUNT: component_count_reg <= cfg_data[2:0];
                CFG_MAX_PARTS:       max_parts_reg       <= cfg_data;
                CFG_MULT_0:          mult_reg[0]         <= cfg_data[3:0];
                CFG_MULT_1:          mult_reg[1]         <= cfg_data[3:0];
                CFG_MULT_2:          mult_reg[2]         <= cfg_data[3:0];
                CFG_MULT_3:          mult_reg[3]         <= cfg_data[3:0];
                default:             ;
            endcase
        end
    end

    // ---------------- stack memory ----------------
    entry_t          mem [STACK_DEPTH];
    entry_t          rd_data_reg;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    entry_t          mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // level bounds; one read address per cycle
    logic [SW-1:0]   level_start_reg [MAX_PARTS + 1];
    logic [LW-1:0]   ls_ridx;
    logic [SW-1:0]   ls_rdata;
    logic            ls_we;
    logic [LW-1:0]   ls_widx;
    logic [SW-1:0]   ls_wdata;
    logic            ls_init;

    assign ls_rdata = level_start_reg[ls_ridx];

    // ---------------- sequencer registers ----------------
    mpe_state_t      state_reg, state_next;
    logic            running_reg, running_next;
    logic [LW-1:0]   level_reg, level_next;
    logic [LW-1:0]   limit_reg, limit_next;
    logic [SW-1:0]   a_reg, a_next;
    logic [SW-1:0]   b_reg, b_next;
    logic [SW-1:0]   j_reg, j_next;
    logic [KW-1:0]   k_reg, k_next;
    logic            tail_reg, tail_next;
    logic [2:0]      m_reg, m_next;
    logic [2:0]      i_reg, i_next;
    logic [LW-1:0]   p_reg, p_next;
    logic [SW-1:0]   e_reg, e_next;
    logic [SW-1:0]   hi_reg, hi_next;
    logic [3:0]      acc_reg [4];
    logic [3:0]      acc_next [4];

    // result register
    logic            out_valid_reg, out_valid_next;
    logic [3:0]      out_index_reg, out_index_next;
    logic [3:0]      out_count_reg [4];
    logic [3:0]      out_count_next [4];
    logic            out_last_reg, out_last_next;
    logic            out_exh_reg, out_exh_next;
    logic            out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // restart arithmetic: clamped component count, total, part limit
    logic [2:0]           m_calc;
    logic [5:0]           total_calc;
    logic [LW-1:0]        limit_calc;
    logic [MULT_BITS-1:0] y_sel;

    always_comb
    begin
        logic [MULT_BITS-1:0] y;
        logic [5:0]           r;
        m_calc = component_count_reg;
        if (m_calc < 3'd1)
        begin
            m_calc = 3'd1;
        end
        if (32'(m_calc) > MAX_M)
        begin
            m_calc = 3'(MAX_M);
        end
        total_calc = 6'd0;
        for (int i = 0; i < NUM_MULT_REGS; i++)
        begin
            y = MULT_BITS'(mult_reg[i]);
            if (y == '0)
            begin
                y = MULT_BITS'(1);
            end
            if (i < 32'(m_calc))
            begin
                total_calc = total_calc + 6'(y);
            end
        end
        r = 6'(max_parts_reg);
        if (r == 6'd0 || r > total_calc)
        begin
            r = total_calc;
        end
        if (32'(r) > MAX_PARTS)
        begin
            r = 6'(MAX_PARTS);
        end
        limit_calc = LW'(r);
        y_sel = MULT_BITS'(mult_reg[i_reg[1:0]]);
        if (y_sel == '0)
        begin
            y_sel = MULT_BITS'(1);
        end
    end

    // pruning product for the part-limit test
    logic [MULT_BITS-1:0] rem_dec;
    logic [PW-1:0]        prune_prod;
    logic [MULT_BITS-1:0] left_calc;

    assign rem_dec    = rd_data_reg.rem - MULT_BITS'(1);
    assign prune_prod = PW'(rem_dec) * PW'(limit_reg - level_reg);
    assign left_calc  = rd_data_reg.tot - rd_data_reg.rem;

    logic [SW-1:0] k_clamp;
    assign k_clamp = (k_reg > KW'(STACK_DEPTH)) ? SW'(STACK_DEPTH) : SW'(k_reg);

    assign in_stall = (state_reg != ST_IDLE);

    // ---------------- next state and datapath control ----------------
    always_comb
    begin
        logic tail_now;
        state_next     = state_reg;
        running_next   = running_reg;
        level_next     = level_reg;
        limit_next     = limit_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        tail_next      = tail_reg;
        m_next         = m_reg;
        i_next         = i_reg;
        p_next         = p_reg;
        e_next         = e_reg;
        hi_next        = hi_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_index_next = out_index_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;
        out_exh_next   = out_exh_reg;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        ls_ridx        = '0;
        ls_we          = 1'b0;
        ls_widx        = '0;
        ls_wdata       = '0;
        ls_init        = 1'b0;
        tail_now       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (restart)
                    begin
                        m_next     = m_calc;
                        limit_next = limit_calc;
                        i_next     = 3'd0;
                        state_next = ST_RS_PUSH;
                    end
                    else if (!running_reg)
                    begin
                        state_next = ST_EX_OUT;
                    end
                    else
                    begin
                        j_next     = b_reg;
                        state_next = ST_M5_CHK;
                    end
                end
            end

            ST_RS_PUSH:
            begin
                // one whole-multiplicity entry per component
                mem_we         = 1'b1;
                mem_waddr      = AW'(i_reg);
                mem_wdata.comp = COMP_BITS'(i_reg);
                mem_wdata.tot  = y_sel;
                mem_wdata.rem  = y_sel;
                i_next         = i_reg + 3'd1;
                if (i_reg == m_reg - 3'd1)
                begin
                    ls_init      = 1'b1;
                    a_next       = '0;
                    b_next       = SW'(m_reg);
                    level_next   = '0;
                    running_next = 1'b1;
                    p_next       = '0;
                    e_next       = '0;
                    state_next   = ST_EM_HI;
                end
            end

            ST_M5_CHK:
            begin
                if (j_reg > a_reg)
                begin
                    j_next     = j_reg - SW'(1);
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(j_reg - SW'(1));
                    state_next = ST_M5_EV;
                end
                else
                begin
                    state_next = ST_EX_OUT;
                end
            end

            ST_M5_EV:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg[AW-1:0];
                mem_wdata = rd_data_reg;
                if (rd_data_reg.rem != '0)
                begin
                    mem_wdata.rem = rem_dec;
                    if (j_reg != a_reg || prune_prod >= PW'(rd_data_reg.tot))
                    begin
                        state_next = ST_M2_START;
                    end
                    else if (level_reg == '0)
                    begin
                        state_next = ST_EX_OUT;
                    end
                    else
                    begin
                        // back up one level and keep scanning
                        level_next = level_reg - LW'(1);
                        ls_ridx    = level_reg - LW'(1);
                        b_next     = a_reg;
                        a_next     = ls_rdata;
                        j_next     = a_reg;
                        state_next = ST_M5_CHK;
                    end
                end
                else
                begin
                    mem_wdata.rem = rd_data_reg.tot;
                    state_next    = ST_M5_CHK;
                end
            end

            ST_M2_START:
            begin
                j_next     = a_reg;
                k_next     = KW'(b_reg);
                tail_next  = 1'b0;
                state_next = ST_M2_RD;
            end

            ST_M2_RD:
            begin
                if (j_reg < b_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = j_reg[AW-1:0];
                    state_next = ST_M2_EV;
                end
                else
                begin
                    state_next = ST_M2_END;
                end
            end

            ST_M2_EV:
            begin
                tail_now  = tail_reg || (left_calc < rd_data_reg.rem);
                tail_next = tail_now;
                mem_wdata.comp = rd_data_reg.comp;
                mem_wdata.tot  = left_calc;
                mem_wdata.rem  = tail_now ? left_calc : rd_data_reg.rem;
                mem_waddr      = k_reg[AW-1:0];
                if (!tail_now || left_calc != '0)
                begin
                    mem_we = (k_reg < KW'(STACK_DEPTH));
                    k_next = k_reg + KW'(1);
                end
                j_next     = j_reg + SW'(1);
                state_next = ST_M2_RD;
            end

            ST_M2_END:
            begin
                if (k_clamp == b_reg)
                begin
                    p_next     = '0;
                    e_next     = '0;
                    state_next = ST_EM_HI;
                end
                else if ((LW + 1)'(level_reg) + (LW + 1)'(1) >= (LW + 1)'(limit_reg) ||
                         (LW + 1)'(level_reg) + (LW + 1)'(2) > (LW + 1)'(MAX_PARTS))
                begin
                    j_next     = b_reg;
                    state_next = ST_M5_CHK;
                end
                else
                begin
                    // open a new level
                    a_next     = b_reg;
                    b_next     = k_clamp;
                    level_next = level_reg + LW'(1);
                    ls_we      = 1'b1;
                    ls_widx    = level_reg + LW'(2);
                    ls_wdata   = k_clamp;
                    state_next = ST_M2_START;
                end
            end

            ST_EM_HI:
            begin
                ls_ridx     = p_reg + LW'(1);
                hi_next     = ls_rdata;
                acc_next[0] = 4'd0;
                acc_next[1] = 4'd0;
                acc_next[2] = 4'd0;
                acc_next[3] = 4'd0;
                state_next  = ST_EM_RD;
            end

            ST_EM_RD:
            begin
                if (e_reg < hi_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = e_reg[AW-1:0];
                    state_next = ST_EM_ACC;
                end
                else
                begin
                    state_next = ST_EM_OUT;
                end
            end

            ST_EM_ACC:
            begin
                acc_next[rd_data_reg.comp] = 4'(rd_data_reg.rem);
                e_next     = e_reg + SW'(1);
                state_next = ST_EM_RD;
            end

            ST_EM_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = 4'(p_reg);
                    out_count_next = acc_reg;
                    out_last_next  = (p_reg == level_reg);
                    out_exh_next   = 1'b0;
                    if (p_reg == level_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        p_next     = p_reg + LW'(1);
                        state_next = ST_EM_HI;
                    end
                end
            end

            ST_EX_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_index_next    = 4'd0;
                    out_count_next[0] = 4'd0;
                    out_count_next[1] = 4'd0;
                    out_count_next[2] = 4'd0;
                    out_count_next[3] = 4'd0;
                    out_last_next     = 1'b1;
                    out_exh_next      = 1'b1;
                    running_next      = 1'b0;
                    level_next        = '0;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            running_reg   <= 1'b0;
            level_reg     <= '0;
            limit_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            level_reg     <= level_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        tail_reg      <= tail_next;
        m_reg         <= m_next;
        i_reg         <= i_next;
        p_reg         <= p_next;
        e_reg         <= e_next;
        hi_reg        <= hi_next;
        acc_reg       <= acc_next;
        out_index_reg <= out_index_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
        out_exh_reg   <= out_exh_next;
        if (ls_init)
        begin
            level_start_reg[0] <= '0;
            level_start_reg[1] <= SW'(m_reg);
        end
        if (ls_we)
        begin
            level_start_reg[ls_widx] <= ls_wdata;
        end
    end

    // ---------------- result ports ----------------
    assign out_valid  = out_valid_reg;
    assign part_index = out_index_reg;
    assign count_0    = out_count_reg[0];
    assign count_1    = out_count_reg[1];
    assign count_2    = out_count_reg[2];
    assign count_3    = out_count_reg[3];
    assign last_part  = out_last_reg;
    assign exhausted  = out_exh_reg;

endmodule
